// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: sv/lbpa_pkg.sv
package lbpa_pkg;

	localparam int NUM_BINS_DEF   = 4096;
	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int IDX_W = 12;
	localparam int CNT_W = 32;
	localparam int OUT_W = 54;

	localparam int BP_W   = 14;
	localparam int BSX_W  = 26;
	localparam int BSXX_W = 38;
	localparam int BSY_W  = 46;
	localparam int BSXY_W = 58;
	localparam int PP_W   = 13;
	localparam int PSX_W  = 24;
	localparam int PSY_W  = 44;

	// Fit datapath widths.
	localparam int ACC_W = 128;
	localparam int Q_W   = 58;
	localparam int T1_W  = 86;
	localparam int T2_W  = 74;
	localparam int D_W   = 52;
	localparam int DCNT_W = $clog2(ACC_W);

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_FIRST = 3'd0,
		REG_PEAK_LAST  = 3'd1,
		REG_LOW_FIRST  = 3'd2,
		REG_LOW_LAST   = 3'd3,
		REG_HIGH_FIRST = 3'd4,
		REG_HIGH_LAST  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] peak_first;
		logic [IDX_W-1:0] peak_last;
		logic [IDX_W-1:0] low_first;
		logic [IDX_W-1:0] low_last;
		logic [IDX_W-1:0] high_first;
		logic [IDX_W-1:0] high_last;
	} windows_t;

	typedef struct packed {
		logic [BP_W-1:0]   back_points;
		logic [BSX_W-1:0]  back_sum_x;
		logic [BSXX_W-1:0] back_sum_xx;
		logic [BSY_W-1:0]  back_sum_y;
		logic [BSXY_W-1:0] back_sum_xy;
		logic [PP_W-1:0]   peak_points;
		logic [PSX_W-1:0]  peak_sum_x;
		logic [PSY_W-1:0]  peak_sum_y;
	} sums_t;

	typedef struct packed {
		logic start;
		logic ack;
	} fit_ctl_t;

	typedef struct packed {
		logic             done;
		logic             invalid;
		logic [OUT_W-1:0] bg;
		logic [OUT_W-1:0] net;
	} fit_res_t;

	typedef enum logic [0:0] {
		T_IDLE,
		T_FIT
	} top_state_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_LOAD,
		F_MUL,
		F_ABS,
		F_BIAS,
		F_DIV,
		F_ROUND,
		F_NET,
		F_DONE
	} fit_state_t;

endpackage

// File: sv/linear_background_peak_area_core.sv
// A bin without last_bin is summed at its acceptance edge, one bin per cycle while in_ready is high.
// A bin with last_bin starts the fit. A singular fit ends after the first product pair.
// The length of a full fit is set by the shared shift-add multiplier (one multiplier bit per cycle,
// so the operand values set the length) and by the restoring divider. in_ready stays low during the fit.
// Reset (arst_n low, asynchronous) clears the window registers to 0 and all sums.
module linear_background_peak_area_core #(
	parameter int NUM_BINS   = lbpa_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = lbpa_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = lbpa_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lbpa_pkg::IDX_W-1:0]     bin_index,
	input  logic [lbpa_pkg::CNT_W-1:0]     bin_count,
	input  logic                           last_bin,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [lbpa_pkg::OUT_W-1:0] net_area,
	output logic signed [lbpa_pkg::OUT_W-1:0] background_sum,
	output logic                           fit_invalid,
	input  logic                           cfg_we,
	input  logic [lbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbpa_pkg::IDX_W-1:0]     cfg_data
);
	import lbpa_pkg::*;
	`include "assert_macros.svh"

	top_state_t       state_q, state_d;
	windows_t         win_q;
	sums_t            sums;
	fit_ctl_t         fit_ctl;
	fit_res_t         fit_res;
	logic             accept, out_free, load_out;
	logic             out_valid_q, fit_invalid_q;
	logic [OUT_W-1:0] net_area_q, background_sum_q;

	// Window registers. Writes to indexes beyond the six windows edges are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PEAK_FIRST: win_q.peak_first <= cfg_data;
				REG_PEAK_LAST:  win_q.peak_last  <= cfg_data;
				REG_LOW_FIRST:  win_q.low_first  <= cfg_data;
				REG_LOW_LAST:   win_q.low_last   <= cfg_data;
				REG_HIGH_FIRST: win_q.high_first <= cfg_data;
				REG_HIGH_LAST:  win_q.high_last  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A request is accepted only in T_IDLE. The result register is separate, so a
	// new histogram may stream in while the previous result waits to be taken.
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:  if (accept && last_bin) state_d = T_FIT;
			T_FIT:   if (fit_res.done && out_free) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == T_IDLE);
		load_out      = (state_q == T_FIT) && fit_res.done && out_free;
		fit_ctl.start = accept && last_bin;
		fit_ctl.ack   = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			net_area_q       <= fit_res.net;
			background_sum_q <= fit_res.bg;
			fit_invalid_q    <= fit_res.invalid;
		end
	end

	// The sums clear once the fit result has moved into the output register.
	lbpa_accum #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (accept),
		.clear (load_out),
		.idx   (bin_index),
		.cnt   (bin_count),
		.win   (win_q),
		.sums  (sums)
	);

	lbpa_fit #(
		.FRAC_BITS(FRAC_BITS)
	) u_fit (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (fit_ctl),
		.sums  (sums),
		.res   (fit_res)
	);

	assign out_valid      = out_valid_q;
	assign net_area       = net_area_q;
	assign background_sum = background_sum_q;
	assign fit_invalid    = fit_invalid_q;

	`ASSERT_NEXT(a_last_blocks_input, accept && last_bin, !in_ready, "input taken during fit")
	`ASSERT_IMPL(a_out_from_fit, $rose(out_valid), $past(state_q == T_FIT), "result without fit")
	`ASSERT_IMPL(a_invalid_zero_bg, out_valid && fit_invalid, background_sum == '0, "singular fit with background")

endmodule

// File: sv/lbpa_accum.sv
module lbpa_accum #(
	parameter int NUM_BINS   = lbpa_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS = lbpa_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       clear,
	input  logic [lbpa_pkg::IDX_W-1:0] idx,
	input  logic [lbpa_pkg::CNT_W-1:0] cnt,
	input  lbpa_pkg::windows_t         win,
	output lbpa_pkg::sums_t            sums
);
	import lbpa_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MASK = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

	sums_t             sums_q;
	logic              idx_ok, lo_hit, hi_hit, pk_hit, any_hit, both_hit;
	logic [CNT_W-1:0]  y;
	logic [23:0]       xx;
	logic [PSY_W-1:0]  xy;

	always_comb begin
		idx_ok   = (32'(idx) < 32'(NUM_BINS));
		lo_hit   = (idx >= win.low_first) && (idx <= win.low_last);
		hi_hit   = (idx >= win.high_first) && (idx <= win.high_last);
		pk_hit   = (idx >= win.peak_first) && (idx <= win.peak_last);
		any_hit  = lo_hit | hi_hit;
		both_hit = lo_hit & hi_hit;
		y        = cnt & CNT_MASK;
		xx       = 24'(idx) * 24'(idx);
		xy       = PSY_W'(idx) * PSY_W'(y);
	end

	// A bin inside both background windows counts twice: add it shifted by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (clear) begin
			sums_q <= '0;
		end else if (en && idx_ok) begin
			if (any_hit) begin
				sums_q.back_points <= sums_q.back_points + (BP_W'(1) << both_hit);
				sums_q.back_sum_x  <= sums_q.back_sum_x + (BSX_W'(idx) << both_hit);
				sums_q.back_sum_xx <= sums_q.back_sum_xx + (BSXX_W'(xx) << both_hit);
				sums_q.back_sum_y  <= sums_q.back_sum_y + (BSY_W'(y) << both_hit);
				sums_q.back_sum_xy <= sums_q.back_sum_xy + (BSXY_W'(xy) << both_hit);
			end
			if (pk_hit) begin
				sums_q.peak_points <= sums_q.peak_points + PP_W'(1);
				sums_q.peak_sum_x  <= sums_q.peak_sum_x + PSX_W'(idx);
				sums_q.peak_sum_y  <= sums_q.peak_sum_y + PSY_W'(y);
			end
		end
	end

	assign sums = sums_q;

endmodule

// File: sv/lbpa_fit.sv
module lbpa_fit #(
	parameter int FRAC_BITS = lbpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbpa_pkg::fit_ctl_t ctl,
	input  lbpa_pkg::sums_t    sums,
	output lbpa_pkg::fit_res_t res
);
	import lbpa_pkg::*;
	`include "assert_macros.svh"

	localparam int NET_W = ((PSY_W + FRAC_BITS > OUT_W) ? PSY_W + FRAC_BITS : OUT_W) + 2;
	localparam logic [NET_W-1:0] NMAX = {{(NET_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic [NET_W-1:0] NMIN = ~NMAX;
	localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	fit_state_t          state_q, state_d;
	logic [2:0]          phase_q;
	logic [ACC_W-1:0]    acc_q, m_q, m_sel;
	logic [Q_W-1:0]      q_q, q_sel;
	logic                sub_q, sub_sel, clr_sel;
	logic [D_W-1:0]      d_q;
	logic [T1_W-1:0]     t1_q;
	logic [T2_W-1:0]     t2_q;
	logic                neg_q, inv_q;
	logic [D_W:0]        rem_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [OUT_W-1:0]    bg_q, net_q;
	logic                d_bad, mul_end;
	logic [D_W+1:0]      sh, dd, sh_sub;
	logic                ge;
	logic [OUT_W-1:0]    lim, mag, bgv;
	logic [NET_W-1:0]    diff;

	// Operand pairs: D = n*Sxx - Sx*Sx, T1 = Sy*Sxx - Sx*Sxy, T2 = n*Sxy - Sx*Sy,
	// then numerator = T1*Np + T2*SxP. Even steps start from a cleared accumulator.
	always_comb begin
		m_sel   = '0;
		q_sel   = '0;
		sub_sel = phase_q[0] && (phase_q < 3'd6);
		clr_sel = !phase_q[0];
		case (phase_q)
			3'd0: begin m_sel = ACC_W'(sums.back_points); q_sel = Q_W'(sums.back_sum_xx); end
			3'd1: begin m_sel = ACC_W'(sums.back_sum_x);  q_sel = Q_W'(sums.back_sum_x);  end
			3'd2: begin m_sel = ACC_W'(sums.back_sum_y);  q_sel = Q_W'(sums.back_sum_xx); end
			3'd3: begin m_sel = ACC_W'(sums.back_sum_x);  q_sel = Q_W'(sums.back_sum_xy); end
			3'd4: begin m_sel = ACC_W'(sums.back_points); q_sel = Q_W'(sums.back_sum_xy); end
			3'd5: begin m_sel = ACC_W'(sums.back_sum_x);  q_sel = Q_W'(sums.back_sum_y);  end
			3'd6: begin
				m_sel = {{(ACC_W-T1_W){t1_q[T1_W-1]}}, t1_q};
				q_sel = Q_W'(sums.peak_points);
			end
			default: begin
				m_sel = {{(ACC_W-T2_W){t2_q[T2_W-1]}}, t2_q};
				q_sel = Q_W'(sums.peak_sum_x);
			end
		endcase
	end

	always_comb begin
		mul_end = (q_q == '0);
		d_bad   = acc_q[ACC_W-1] || (acc_q == '0);
		sh      = {rem_q, acc_q[ACC_W-1]};
		dd      = {1'b0, d_q, 1'b0};
		ge      = (sh >= dd);
		sh_sub  = sh - dd;
		lim     = neg_q ? LIM_NEG : LIM_POS;
		if ((acc_q[ACC_W-1:OUT_W] != '0) || (acc_q[OUT_W-1:0] > lim)) begin
			mag = lim;
		end else begin
			mag = acc_q[OUT_W-1:0];
		end
		bgv  = inv_q ? '0 : bg_q;
		diff = (NET_W'(sums.peak_sum_y) << FRAC_BITS) - {{(NET_W-OUT_W){bgv[OUT_W-1]}}, bgv};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (ctl.start) state_d = F_LOAD;
			F_LOAD:  state_d = F_MUL;
			F_MUL: begin
				if (mul_end) begin
					if ((phase_q == 3'd1) && d_bad) state_d = F_NET;
					else if (phase_q == 3'd7) state_d = F_ABS;
					else state_d = F_LOAD;
				end
			end
			F_ABS:   state_d = F_BIAS;
			F_BIAS:  state_d = F_DIV;
			F_DIV:   if (cnt_q == '0) state_d = F_ROUND;
			F_ROUND: state_d = F_NET;
			F_NET:   state_d = F_DONE;
			F_DONE:  if (ctl.ack) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= '0;
			inv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == F_IDLE) begin
				phase_q <= '0;
				inv_q   <= 1'b0;
			end else if ((state_q == F_MUL) && mul_end) begin
				phase_q <= phase_q + 3'd1;
				if (phase_q == 3'd1) inv_q <= d_bad;
			end
		end
	end

	// Shared datapath: shift-add multiply, magnitude and bias, restoring divide, clamp and net.
	always_ff @(posedge clk) begin
		case (state_q)
			F_LOAD: begin
				m_q   <= m_sel;
				q_q   <= q_sel;
				sub_q <= sub_sel;
				if (clr_sel) acc_q <= '0;
			end
			F_MUL: begin
				if (!mul_end) begin
					if (q_q[0]) acc_q <= sub_q ? (acc_q - m_q) : (acc_q + m_q);
					m_q <= m_q << 1;
					q_q <= q_q >> 1;
				end else begin
					case (phase_q)
						3'd1:    d_q  <= acc_q[D_W-1:0];
						3'd3:    t1_q <= acc_q[T1_W-1:0];
						3'd5:    t2_q <= acc_q[T2_W-1:0];
						default: ;
					endcase
				end
			end
			F_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				if (acc_q[ACC_W-1]) acc_q <= -acc_q;
			end
			F_BIAS: begin
				acc_q <= (acc_q << (FRAC_BITS + 1)) + ACC_W'(d_q);
				rem_q <= '0;
				cnt_q <= DCNT_W'(ACC_W - 1);
			end
			F_DIV: begin
				rem_q <= ge ? sh_sub[D_W:0] : sh[D_W:0];
				acc_q <= {acc_q[ACC_W-2:0], ge};
				cnt_q <= cnt_q - DCNT_W'(1);
			end
			F_ROUND: bg_q <= neg_q ? -mag : mag;
			F_NET: begin
				bg_q <= bgv;
				if ($signed(diff) > $signed(NMAX)) net_q <= NMAX[OUT_W-1:0];
				else if ($signed(diff) < $signed(NMIN)) net_q <= NMIN[OUT_W-1:0];
				else net_q <= diff[OUT_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		res.done    = (state_q == F_DONE);
		res.invalid = inv_q;
		res.bg      = bg_q;
		res.net     = net_q;
	end

	`ASSERT_IMPL(a_div_by_nonzero, state_q == F_DIV, d_q != '0, "divide entered with zero denominator")
	`ASSERT_NEXT(a_done_holds, (state_q == F_DONE) && !ctl.ack, state_q == F_DONE, "result dropped before ack")

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import lbpa_pkg::*;

	// Clock, reset and the ports of the block.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IDX_W-1:0] bin_index = '0;
	logic [CNT_W-1:0] bin_count = '0;
	logic last_bin = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] net_area;
	logic signed [OUT_W-1:0] background_sum;
	logic fit_invalid;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PEAK_FIRST;
	logic [IDX_W-1:0] cfg_data = '0;

	linear_background_peak_area_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.bin_index(bin_index), .bin_count(bin_count), .last_bin(last_bin),
		.out_valid(out_valid), .out_ready(out_ready),
		.net_area(net_area), .background_sum(background_sum), .fit_invalid(fit_invalid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// One expected area result.
	typedef struct {
		logic signed [OUT_W-1:0] net;
		logic signed [OUT_W-1:0] bg;
		logic                    inv;
	} area_t;

	area_t area_q[$];
	int errors = 0;
	int bins_sent = 0;
	// When calm is set, neither side idles; this gives long back-to-back stretches.
	bit calm = 0;

	// The testbench's own copy of the window registers and the running sums.
	logic [IDX_W-1:0] win[6];
	logic [BP_W-1:0]   m_bp;
	logic [BSX_W-1:0]  m_bsx;
	logic [BSXX_W-1:0] m_bsxx;
	logic [BSY_W-1:0]  m_bsy;
	logic [BSXY_W-1:0] m_bsxy;
	logic [PP_W-1:0]   m_pp;
	logic [PSX_W-1:0]  m_psx;
	logic [PSY_W-1:0]  m_psy;

	function automatic bit in_win(logic [IDX_W-1:0] x, logic [IDX_W-1:0] lo,
			logic [IDX_W-1:0] hi);
		return x >= lo && x <= hi;
	endfunction

	function automatic void clear_sums();
		m_bp = '0; m_bsx = '0; m_bsxx = '0; m_bsy = '0; m_bsxy = '0;
		m_pp = '0; m_psx = '0; m_psy = '0;
	endfunction

	function automatic void add_back(logic [IDX_W-1:0] x, logic [CNT_W-1:0] y);
		m_bp   = m_bp + 1'b1;
		m_bsx  = m_bsx + BSX_W'(x);
		m_bsxx = m_bsxx + BSXX_W'(x) * BSXX_W'(x);
		m_bsy  = m_bsy + BSY_W'(y);
		m_bsxy = m_bsxy + BSXY_W'(x) * BSXY_W'(y);
	endfunction

	// Least-squares line through the background sums, summed over the peak bins.
	// The numerator is carried at 192 bits so that its wraparound matches exactly.
	function automatic area_t fit_area();
		area_t r;
		logic [63:0] nxx, sx2, d, lim;
		logic [191:0] t1, t2, num, q;
		logic neg;
		logic signed [63:0] bgs, n64;
		nxx = 64'(m_bp) * 64'(m_bsxx);
		sx2 = 64'(m_bsx) * 64'(m_bsx);
		if (nxx <= sx2) begin
			// Singular fit: no background, raw peak sum.
			r.inv = 1'b1;
			bgs = 0;
		end else begin
			r.inv = 1'b0;
			d = nxx - sx2;
			t1 = 192'(m_bsy) * 192'(m_bsxx) - 192'(m_bsx) * 192'(m_bsxy);
			t2 = 192'(m_bp) * 192'(m_bsxy) - 192'(m_bsx) * 192'(m_bsy);
			num = t1 * 192'(m_pp) + t2 * 192'(m_psx);
			neg = num[191];
			if (neg) begin
				num = -num;
			end
			// Round to nearest, ties away from zero: (2*|num|*2^F + d) / (2*d).
			num = (num << (FRAC_BITS_DEF + 1)) + 192'(d);
			q = num / (192'(d) << 1);
			lim = neg ? (64'd1 << 53) : (64'd1 << 53) - 64'd1;
			if (q > 192'(lim)) begin
				q = 192'(lim);
			end
			bgs = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
		end
		n64 = $signed(64'(m_psy) << FRAC_BITS_DEF) - bgs;
		if (n64 > 64'sd9007199254740991) begin
			n64 = 64'sd9007199254740991;
		end else if (n64 < -64'sd9007199254740992) begin
			n64 = -64'sd9007199254740992;
		end
		r.bg = bgs[OUT_W-1:0];
		r.net = n64[OUT_W-1:0];
		return r;
	endfunction

	// Applies one accepted bin; on the last bin the expected result is queued.
	function automatic void take_bin(logic [IDX_W-1:0] x, logic [CNT_W-1:0] y, logic last);
		if (in_win(x, win[REG_LOW_FIRST], win[REG_LOW_LAST])) begin
			add_back(x, y);
		end
		if (in_win(x, win[REG_HIGH_FIRST], win[REG_HIGH_LAST])) begin
			add_back(x, y);
		end
		if (in_win(x, win[REG_PEAK_FIRST], win[REG_PEAK_LAST])) begin
			m_pp  = m_pp + 1'b1;
			m_psx = m_psx + PSX_W'(x);
			m_psy = m_psy + PSY_W'(y);
		end
		if (last) begin
			area_q.push_back(fit_area());
			clear_sums();
		end
	endfunction

	// Sends one bin request. It returns right after the acceptance edge, with valid
	// still high, so that the next call can drive new data without a gap.
	task automatic send_bin(logic [IDX_W-1:0] x, logic [CNT_W-1:0] y, logic last);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		bin_index <= x;
		bin_count <= y;
		last_bin  <= last;
		do begin
			@(posedge clk);
		end while (!in_ready);
		take_bin(x, y, last);
		bins_sent++;
	endtask

	// Drops valid and waits until every expected result has been checked, plus a
	// short margin so that the block is surely back in its idle state.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (area_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [IDX_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		win[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_windows(logic [IDX_W-1:0] pf, logic [IDX_W-1:0] pl,
			logic [IDX_W-1:0] lf, logic [IDX_W-1:0] ll,
			logic [IDX_W-1:0] hf, logic [IDX_W-1:0] hl);
		wait_drained();
		write_reg(REG_PEAK_FIRST, pf);
		write_reg(REG_PEAK_LAST, pl);
		write_reg(REG_LOW_FIRST, lf);
		write_reg(REG_LOW_LAST, ll);
		write_reg(REG_HIGH_FIRST, hf);
		write_reg(REG_HIGH_LAST, hl);
	endtask

	// With the reset windows all at bin 0, only bin 0 counts, twice in the background.
	task automatic test_reset_windows();
		send_bin(12'd0, 32'd100, 1'b0);
		send_bin(12'd4095, 32'hFFFF_FFFF, 1'b1);
		send_bin(12'd0, 32'hFFFF_FFFF, 1'b1);
	endtask

	// A plain fit with the extremes of index and count, then a background of a single point.
	task automatic test_extremes();
		set_windows(12'd10, 12'd20, 12'd0, 12'd9, 12'd21, 12'd4095);
		send_bin(12'd0, 32'd0, 1'b0);
		send_bin(12'd5, 32'd1000, 1'b0);
		send_bin(12'd15, 32'hFFFF_FFFF, 1'b0);
		send_bin(12'd30, 32'd40, 1'b0);
		send_bin(12'd4095, 32'hFFFF_FFFF, 1'b1);
		// Only one background point: the fit is singular.
		send_bin(12'd12, 32'd77, 1'b0);
		send_bin(12'd3, 32'd9, 1'b1);
	endtask

	// Overlapping background windows, a peak bin inside the background, and an
	// inverted peak window.
	task automatic test_overlap_inverted();
		set_windows(12'd8, 12'd12, 12'd0, 12'd10, 12'd5, 12'd20);
		send_bin(12'd2, 32'd50, 1'b0);
		send_bin(12'd7, 32'd60, 1'b0);
		send_bin(12'd9, 32'd500, 1'b0);
		send_bin(12'd18, 32'd80, 1'b1);
		set_windows(12'd30, 12'd20, 12'd0, 12'd10, 12'd40, 12'd50);
		send_bin(12'd1, 32'd5, 1'b0);
		send_bin(12'd25, 32'd5, 1'b0);
		send_bin(12'd45, 32'd90, 1'b1);
	endtask

	// A steep background extrapolated far out drives the sum past both limits.
	task automatic test_saturation();
		set_windows(12'd4000, 12'd4095, 12'd0, 12'd0, 12'd1, 12'd1);
		send_bin(12'd0, 32'd0, 1'b0);
		send_bin(12'd1, 32'hFFFF_FFFF, 1'b0);
		repeat (4) send_bin(12'd4095, 32'd3, 1'b0);
		send_bin(12'd4090, 32'd1, 1'b1);
		send_bin(12'd0, 32'hFFFF_FFFF, 1'b0);
		send_bin(12'd1, 32'd0, 1'b0);
		repeat (4) send_bin(12'd4095, 32'hFFFF_FFFF, 1'b0);
		send_bin(12'd4094, 32'd1, 1'b1);
	endtask

	function automatic logic [CNT_W-1:0] rand_count();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			return CNT_W'($urandom_range(1000));
		end else if (pick < 80) begin
			return $urandom;
		end
		return $urandom_range(1) ? '1 : '0;
	endfunction

	// Random histograms around randomly placed windows. Most bins fall near the
	// windows; a few are anywhere, and a few carry an early last_bin.
	task automatic test_random();
		logic [IDX_W-1:0] base, x;
		int len, k;
		while (bins_sent < 1970) begin
			base = IDX_W'($urandom_range(4095 - 80));
			case ($urandom_range(9))
				0: set_windows('0, '1, '0, '1, '0, '1);
				1: set_windows('1, '1, '0, '0, '1, '0);
				default: begin
					set_windows(base + IDX_W'($urandom_range(63)),
						base + IDX_W'($urandom_range(63)),
						base + IDX_W'($urandom_range(63)),
						base + IDX_W'($urandom_range(63)),
						base + IDX_W'($urandom_range(63)),
						base + IDX_W'($urandom_range(63)));
				end
			endcase
			calm = ($urandom_range(5) == 0);
			repeat ($urandom_range(1, 5)) begin
				len = $urandom_range(1, 30);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(9) == 0) begin
						x = IDX_W'($urandom);
					end else begin
						x = base + IDX_W'($urandom_range(79));
					end
					send_bin(x, rand_count(), (k == len - 1) || ($urandom_range(49) == 0));
				end
			end
		end
		calm = 0;
	endtask

	// The receiving side stalls at random, except during calm stretches.
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 37);
	end

	// Compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		area_t e;
		if (arst_n && out_valid && out_ready) begin
			if (area_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = area_q.pop_front();
				if (net_area !== e.net) begin
					$error("net_area expected %0d actual %0d", e.net, net_area);
					errors++;
				end
				if (background_sum !== e.bg) begin
					$error("background_sum expected %0d actual %0d", e.bg, background_sum);
					errors++;
				end
				if (fit_invalid !== e.inv) begin
					$error("fit_invalid expected %0b actual %0b", e.inv, fit_invalid);
					errors++;
				end
			end
		end
	end

	initial begin
		foreach (win[i]) win[i] = '0;
		clear_sums();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_windows();
		test_extremes();
		test_overlap_inverted();
		test_saturation();
		test_random();
		wait_drained();
		repeat (500) @(posedge clk);
		if (errors == 0 && area_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
